### rtl/rrp_pkg.sv
// ----------------------------------------------------------------------------
// rrp_pkg: shared types and constants for the relocation patch unit
// Relocation methods, status codes, segment codes, opcodes and the
// structures passed between the datapath and the top level.
// ----------------------------------------------------------------------------
package rrp_pkg;

  typedef enum logic [2:0] {
    MODE_WORD32   = 3'd0,
    MODE_BRANCH12 = 3'd1,
    MODE_LOAD12   = 3'd2,
    MODE_HIGH20   = 3'd3,
    MODE_STORE12  = 3'd4,
    MODE_JAL20    = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_ODD_DISP = 2'd1,
    ST_BAD_SEG  = 2'd2,
    ST_BAD_MODE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    SEG_ABS  = 2'd0,
    SEG_CODE = 2'd1,
    SEG_DATA = 2'd2,
    SEG_BSS  = 2'd3
  } seg_e;

  typedef enum logic [1:0] {
    CFG_COMPRESS_EN = 2'd0,
    CFG_CODE_BASE   = 2'd1,
    CFG_DATA_BASE   = 2'd2,
    CFG_BSS_BASE    = 2'd3
  } cfg_idx_e;

  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_JAL    = 7'h6F;
  localparam logic [2:0] F3_WORD    = 3'b010;
  localparam logic [4:0] REG_RA     = 5'd1;
  localparam logic [4:0] REG_ZERO   = 5'd0;

  typedef struct packed {
    logic        compress_en;
    logic [31:0] code_base;
    logic [31:0] data_base;
    logic [31:0] bss_base;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [1:0]  own_segment;
    logic [1:0]  target_segment;
    logic [31:0] patch_offset;
    logic [31:0] addend;
    logic [31:0] shrink_delta;
    logic [31:0] instr_word;
  } reloc_t;

  typedef struct packed {
    logic [31:0] patched_word;
    logic        compressed;
    logic [1:0]  status;
  } result_t;

  // Load address of a segment; abs starts at zero.
  function automatic logic [31:0] seg_base(logic [1:0] seg, cfg_t cfg);
    logic [31:0] base;
    unique case (seg_e'(seg))
      SEG_CODE: base = cfg.code_base;
      SEG_DATA: base = cfg.data_base;
      SEG_BSS:  base = cfg.bss_base;
      default:  base = 32'd0;
    endcase
    return base;
  endfunction

  // Compressed register file holds x8..x15.
  function automatic logic is_creg(logic [4:0] r);
    return r[4:3] == 2'b01;
  endfunction

endpackage

### rtl/rrp_patch_core.sv
// ----------------------------------------------------------------------------
// rrp_patch_core: displacement and field insertion datapath
// Forms the displacement for one relocation and builds either the patched
// 32-bit word or its 16-bit compressed form, with status.
// ----------------------------------------------------------------------------
module rrp_patch_core (
  input  rrp_pkg::cfg_t    cfg_i,
  input  rrp_pkg::reloc_t  reloc_i,
  output rrp_pkg::result_t result_o
);

  logic [31:0] w;
  logic [6:0]  opc;
  logic [2:0]  f3;
  logic [4:0]  rd, ra, rb, r2;
  logic [31:0] base_tgt, base_own;
  logic [31:0] seg_diff;   // target start - own start
  logic [31:0] disp_pc;    // addend - offset - delta
  logic [31:0] disp_abs;   // addend + target start - delta
  logic [31:0] disp_rel;   // pc-relative, corrected for segment starts
  logic [11:0] v_ls;
  logic [19:0] hi20;
  logic        is_load;
  logic        br_ok, jal_ok, ls_ok;
  logic [15:0] c_br, c_jal, c_ls;
  logic [31:0] word_d;
  logic        cmp_d;
  logic [1:0]  st_d;

  assign w   = reloc_i.instr_word;
  assign opc = w[6:0];
  assign f3  = w[14:12];
  assign rd  = w[11:7];
  assign ra  = w[19:15];
  assign rb  = w[24:20];

  assign base_tgt = rrp_pkg::seg_base(reloc_i.target_segment, cfg_i);
  assign base_own = rrp_pkg::seg_base(reloc_i.own_segment, cfg_i);

  assign seg_diff = base_tgt - base_own;
  assign disp_pc  = reloc_i.addend - reloc_i.patch_offset - reloc_i.shrink_delta;
  assign disp_abs = reloc_i.addend + base_tgt - reloc_i.shrink_delta;
  assign disp_rel = disp_pc + seg_diff;
  assign v_ls     = disp_rel[11:0] + 12'd4;
  // upper part rounds up when bit 11 is set
  assign hi20     = disp_rel[31:12] + {19'd0, disp_rel[11]};

  assign is_load = (reloc_i.mode == rrp_pkg::MODE_LOAD12);
  assign r2      = is_load ? rd : rb;

  // c.beqz / c.bnez: offset must fit 9 signed bits
  assign br_ok = cfg_i.compress_en && (opc == rrp_pkg::OPC_BRANCH) && (f3[2:1] == 2'b00) &&
                 (rb == rrp_pkg::REG_ZERO) && rrp_pkg::is_creg(ra) &&
                 ((disp_pc[12:8] == 5'b00000) || (disp_pc[12:8] == 5'b11111));
  assign c_br  = {2'b11, f3[0], disp_pc[8], disp_pc[4:3], ra[2:0], disp_pc[7:6],
                  disp_pc[2:1], disp_pc[5], 1'b0, 1'b1};

  // c.jal: offset must fit 12 signed bits
  assign jal_ok = cfg_i.compress_en && (opc == rrp_pkg::OPC_JAL) && (rd == rrp_pkg::REG_RA) &&
                  ((disp_pc[20:11] == 10'h000) || (disp_pc[20:11] == 10'h3FF));
  assign c_jal  = {2'b00, 1'b1, disp_pc[11], disp_pc[4], disp_pc[9:8], disp_pc[10],
                   disp_pc[6], disp_pc[7], disp_pc[3:1], disp_pc[5], 1'b0, 1'b1};

  // c.lw / c.sw: offset 0..124, word aligned
  assign ls_ok = cfg_i.compress_en &&
                 (opc == (is_load ? rrp_pkg::OPC_LOAD : rrp_pkg::OPC_STORE)) &&
                 (f3 == rrp_pkg::F3_WORD) && rrp_pkg::is_creg(ra) && rrp_pkg::is_creg(r2) &&
                 (v_ls[11:7] == 5'd0) && (v_ls[1:0] == 2'b00);
  assign c_ls  = {(is_load ? 3'b010 : 3'b110), v_ls[5:3], ra[2:0], v_ls[2], v_ls[6],
                  r2[2:0], 2'b00};

  always_comb begin
    word_d = w;
    cmp_d  = 1'b0;
    st_d   = rrp_pkg::ST_OK;
    priority if ((reloc_i.own_segment == rrp_pkg::SEG_ABS) ||
                 (reloc_i.own_segment == rrp_pkg::SEG_BSS)) begin
      st_d = rrp_pkg::ST_BAD_SEG;
    end else begin
      unique case (reloc_i.mode)
        rrp_pkg::MODE_WORD32: begin
          word_d = disp_abs;
        end
        rrp_pkg::MODE_BRANCH12: begin
          if (disp_pc[0]) begin
            st_d = rrp_pkg::ST_ODD_DISP;
          end else if (br_ok) begin
            word_d = {16'd0, c_br};
            cmp_d  = 1'b1;
          end else begin
            word_d = w | {disp_pc[12], disp_pc[10:5], 13'd0, disp_pc[4:1], disp_pc[11], 7'd0};
          end
        end
        rrp_pkg::MODE_JAL20: begin
          if (disp_pc[0]) begin
            st_d = rrp_pkg::ST_ODD_DISP;
          end else if (jal_ok) begin
            word_d = {16'd0, c_jal};
            cmp_d  = 1'b1;
          end else begin
            word_d = w | {disp_pc[20], disp_pc[10:1], disp_pc[11], disp_pc[19:12], 12'd0};
          end
        end
        rrp_pkg::MODE_HIGH20: begin
          word_d = w | {hi20, 12'd0};
        end
        rrp_pkg::MODE_LOAD12, rrp_pkg::MODE_STORE12: begin
          if (ls_ok) begin
            word_d = {16'd0, c_ls};
            cmp_d  = 1'b1;
          end else if (is_load) begin
            word_d = w | {v_ls, 20'd0};
          end else begin
            word_d = w | {v_ls[11:5], 13'd0, v_ls[4:0], 7'd0};
          end
        end
        default: begin
          st_d = rrp_pkg::ST_BAD_MODE;
        end
      endcase
    end
  end

  assign result_o.patched_word = word_d;
  assign result_o.compressed   = cmp_d;
  assign result_o.status       = st_d;

endmodule

### rtl/riscv_reloc_patch_rvc_unit.sv
// ----------------------------------------------------------------------------
// riscv_reloc_patch_rvc_unit: relocation patcher with RVC compression
// Patches one relocation per cycle into an instruction word, while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one relocation request:
//   method, own and target segment, patch offset, addend, shrink delta and
//   the original instruction word. Output channel (out_valid_o /
//   out_ready_i) returns the patched word, the compressed flag and status.
//   Config channel (cfg_valid_i / cfg_ready_o) writes the compress enable
//   and the three segment start addresses; it is always ready. Write it
//   only while no request is in flight.
//   A request accepted into the request register passes through the patch
//   datapath into the result register. Throughput: one request per cycle
//   while the output is not stalled; the result register drives the output.
//   Reset clears the config registers to zero and empties both stages.
//   When the receiver stalls, the result register holds and an empty request
//   register still takes one more request; after that in_ready_o drops
//   until the output is taken. No request is lost or duplicated.
// ----------------------------------------------------------------------------
module riscv_reloc_patch_rvc_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // request
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  logic [1:0]  own_segment_i,
  input  logic [1:0]  target_segment_i,
  input  logic [31:0] patch_offset_i,
  input  logic [31:0] addend_i,
  input  logic [31:0] shrink_delta_i,
  input  logic [31:0] instr_word_i,
  // result
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] patched_word_o,
  output logic        compressed_o,
  output logic [1:0]  status_o
);

  rrp_pkg::cfg_t    cfg_q;
  rrp_pkg::reloc_t  req_q;
  rrp_pkg::result_t res_d, res_q;
  logic             req_valid_q;
  logic             out_valid_q;
  logic             advance;    // result register may load

  assign cfg_ready_o = 1'b1;

  // Config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (rrp_pkg::cfg_idx_e'(cfg_index_i))
        rrp_pkg::CFG_COMPRESS_EN: cfg_q.compress_en <= cfg_data_i[0];
        rrp_pkg::CFG_CODE_BASE:   cfg_q.code_base   <= cfg_data_i;
        rrp_pkg::CFG_DATA_BASE:   cfg_q.data_base   <= cfg_data_i;
        rrp_pkg::CFG_BSS_BASE:    cfg_q.bss_base    <= cfg_data_i;
        default:                  cfg_q             <= cfg_q;
      endcase
    end
  end

  // Stage control: output register frees when empty or taken
  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = !req_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        req_valid_q <= 1'b1;
      end else if (advance) begin
        req_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= req_valid_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      req_q.mode           <= mode_i;
      req_q.own_segment    <= own_segment_i;
      req_q.target_segment <= target_segment_i;
      req_q.patch_offset   <= patch_offset_i;
      req_q.addend         <= addend_i;
      req_q.shrink_delta   <= shrink_delta_i;
      req_q.instr_word     <= instr_word_i;
    end
    if (advance && req_valid_q) begin
      res_q <= res_d;
    end
  end

  rrp_patch_core u_core (
    .cfg_i    (cfg_q),
    .reloc_i  (req_q),
    .result_o (res_d)
  );

  assign out_valid_o    = out_valid_q;
  assign patched_word_o = res_q.patched_word;
  assign compressed_o   = res_q.compressed;
  assign status_o       = res_q.status;

endmodule

### rtl/rrp_checker.sv
// ----------------------------------------------------------------------------
// rrp_checker: port-level checks for the relocation patch unit
// Watches handshakes and result consistency at the top-level ports.
// ----------------------------------------------------------------------------
module rrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] patched_word_o,
  input logic        compressed_o,
  input logic [1:0]  status_o
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // input only backs up when the output is stalled
  a_ready_bp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // compressed result is a bare halfword
  a_cmp_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compressed_o |-> patched_word_o[31:16] == 16'd0 &&
                                    patched_word_o[1:0] != 2'b11)
    else $error("compressed result not a 16-bit form");

  // only a clean relocation is compressed
  a_cmp_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && compressed_o |-> status_o == rrp_pkg::ST_OK)
    else $error("compressed result with error status");

endmodule

bind riscv_reloc_patch_rvc_unit rrp_checker u_rrp_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .patched_word_o (patched_word_o),
  .compressed_o   (compressed_o),
  .status_o       (status_o)
);

### test/riscv_reloc_patch_rvc_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// riscv_reloc_patch_rvc_unit_tb: self-checking bench for the relocation patcher
// Sends relocation requests through a bursty valid/ready driver and checks each
// patched word, compressed flag and status against an in-bench predictor.
// The run covers several segment layouts, with compression on and off.
// ----------------------------------------------------------------------------
module riscv_reloc_patch_rvc_unit_tb;

  // Method codes the package leaves unnamed; with a valid own segment both come back as bad method.
  localparam logic [2:0] MODE_RSVD6 = 3'd6;
  localparam logic [2:0] MODE_RSVD7 = 3'd7;

  localparam int unsigned SETTLE_CYCLES = 6;    // quiet wait after the last result is back
  localparam int unsigned LONG_HOLD     = 60;   // receiver back-pressure stretch
  localparam int unsigned HOLD_AT       = 150;  // results seen before that stretch
  localparam int unsigned STALL_LIMIT   = 2000; // cycles with no handshake at all

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        cfg_valid = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  logic        cfg_ready_o;

  logic            in_valid = 1'b0;
  rrp_pkg::reloc_t cur_reloc = '0;
  logic            in_ready_o;

  logic        out_ready = 1'b0;
  logic        out_valid_o;
  logic [31:0] patched_word_o;
  logic        compressed_o;
  logic [1:0]  status_o;

  // Shadow of the layout registers, as the block should hold them.
  rrp_pkg::cfg_t    cfg_shadow = '0;

  rrp_pkg::reloc_t  reloc_q[$];      // requests not yet offered
  rrp_pkg::result_t patch_exp_q[$];  // predicted results, oldest first

  int unsigned queued_total = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches = 0;
  int unsigned idle_cycles = 0;
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;
  int unsigned hold_left = 0;
  int unsigned tick = 0;
  bit          long_hold_done = 1'b0;

  riscv_reloc_patch_rvc_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready_o),
    .mode_i           (cur_reloc.mode),
    .own_segment_i    (cur_reloc.own_segment),
    .target_segment_i (cur_reloc.target_segment),
    .patch_offset_i   (cur_reloc.patch_offset),
    .addend_i         (cur_reloc.addend),
    .shrink_delta_i   (cur_reloc.shrink_delta),
    .instr_word_i     (cur_reloc.instr_word),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready),
    .patched_word_o   (patched_word_o),
    .compressed_o     (compressed_o),
    .status_o         (status_o)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic bit chance(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic logic [31:0] seg_start(logic [1:0] seg);
    case (seg)
      rrp_pkg::SEG_CODE: return cfg_shadow.code_base;
      rrp_pkg::SEG_DATA: return cfg_shadow.data_base;
      rrp_pkg::SEG_BSS:  return cfg_shadow.bss_base;
      default:           return 32'd0;
    endcase
  endfunction

  function automatic rrp_pkg::result_t patch_predict(rrp_pkg::reloc_t r);
    logic [31:0] w, v, s, res;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rd, ra, rb, r2;
    logic [1:0]  st;
    logic        cmp, en, ld;
    rrp_pkg::result_t o;
    w   = r.instr_word;
    res = w;
    st  = rrp_pkg::ST_OK;
    cmp = 1'b0;
    en  = cfg_shadow.compress_en;
    op  = w[6:0];
    f3  = w[14:12];
    rd  = w[11:7];
    ra  = w[19:15];
    rb  = w[24:20];
    // segment check wins over the method check
    if (r.own_segment == rrp_pkg::SEG_ABS || r.own_segment == rrp_pkg::SEG_BSS) begin
      st = rrp_pkg::ST_BAD_SEG;
    end else if (r.mode > rrp_pkg::MODE_JAL20) begin
      st = rrp_pkg::ST_BAD_MODE;
    end else if (r.mode == rrp_pkg::MODE_WORD32) begin
      res = r.addend + seg_start(r.target_segment) - r.shrink_delta;
    end else if (r.mode == rrp_pkg::MODE_BRANCH12 || r.mode == rrp_pkg::MODE_JAL20) begin
      v = r.addend - r.patch_offset - r.shrink_delta;
      if (v[0]) begin
        st = rrp_pkg::ST_ODD_DISP;
      end else if (r.mode == rrp_pkg::MODE_BRANCH12) begin
        s = {{19{v[12]}}, v[12:0]};
        // c.beqz / c.bnez: rs2 = x0, rs1 in x8..x15, -256..255
        if (en && op == rrp_pkg::OPC_BRANCH && f3[2:1] == 2'b00 && rb == rrp_pkg::REG_ZERO &&
            ra[4:3] == 2'b01 && $signed(s) >= -256 && $signed(s) <= 255) begin
          res = {16'd0, 2'b11, f3[0], v[8], v[4:3], ra[2:0], v[7:6], v[2:1], v[5], 2'b01};
          cmp = 1'b1;
        end else begin
          res = w | {v[12], v[10:5], 13'd0, v[4:1], v[11], 7'd0};
        end
      end else begin
        s = {{11{v[20]}}, v[20:0]};
        // c.jal: rd = ra, -2048..2047
        if (en && op == rrp_pkg::OPC_JAL && rd == rrp_pkg::REG_RA &&
            $signed(s) >= -2048 && $signed(s) <= 2047) begin
          res = {16'd0, 3'b001, v[11], v[4], v[9:8], v[10], v[6], v[7], v[3:1], v[5], 2'b01};
          cmp = 1'b1;
        end else begin
          res = w | {v[20], v[10:1], v[11], v[19:12], 12'd0};
        end
      end
    end else if (r.mode == rrp_pkg::MODE_HIGH20) begin
      v = r.addend - r.patch_offset - r.shrink_delta + seg_start(r.target_segment)
          - seg_start(r.own_segment);
      if (v[11]) v = v + 32'h1000;  // round for the signed low part
      res = w | {v[31:12], 12'd0};
    end else begin
      ld = (r.mode == rrp_pkg::MODE_LOAD12);
      r2 = ld ? rd : rb;
      v  = r.addend - r.patch_offset - r.shrink_delta + 32'd4
           + seg_start(r.target_segment) - seg_start(r.own_segment);
      v  = {20'd0, v[11:0]};
      s  = {{20{v[11]}}, v[11:0]};
      // c.lw / c.sw: word access, both registers compressible, 0..124 step 4
      if (en && op == (ld ? rrp_pkg::OPC_LOAD : rrp_pkg::OPC_STORE) &&
          f3 == rrp_pkg::F3_WORD && ra[4:3] == 2'b01 && r2[4:3] == 2'b01 &&
          s <= 32'd124 && s[1:0] == 2'b00) begin
        res = {16'd0, (ld ? 3'b010 : 3'b110), v[5:3], ra[2:0], v[2], v[6], r2[2:0], 2'b00};
        cmp = 1'b1;
      end else if (ld) begin
        res = w | {v[11:0], 20'd0};
      end else begin
        res = w | {v[11:5], 13'd0, v[4:0], 7'd0};
      end
    end
    o.patched_word = res;
    o.compressed   = cmp;
    o.status       = st;
    return o;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // Addend that makes the method see displacement disp under the current layout.
  function automatic logic [31:0] addend_for(logic [2:0] mode, logic [1:0] own,
                                             logic [1:0] tgt, logic [31:0] pofs,
                                             logic [31:0] dlt, logic [31:0] disp);
    case (mode)
      rrp_pkg::MODE_WORD32:   return disp + dlt - seg_start(tgt);
      rrp_pkg::MODE_BRANCH12,
      rrp_pkg::MODE_JAL20:    return disp + pofs + dlt;
      rrp_pkg::MODE_HIGH20:   return disp + pofs + dlt - seg_start(tgt) + seg_start(own);
      default: return disp + pofs + dlt - 32'd4 - seg_start(tgt) + seg_start(own);
    endcase
  endfunction

  function automatic logic [31:0] rv_word(logic [6:0] op, logic [2:0] f3, logic [4:0] rd,
                                          logic [4:0] rs1, logic [4:0] rs2);
    return {7'd0, rs2, rs1, f3, rd, op};
  endfunction

  // Mostly x8..x15 so compressed forms stay reachable.
  function automatic logic [4:0] pick_reg();
    return chance(85) ? {2'b01, 3'($urandom_range(7))} : 5'($urandom);
  endfunction

  function automatic rrp_pkg::reloc_t rand_reloc();
    rrp_pkg::reloc_t r;
    logic [31:0] d, mask;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  rd, ra, rb;
    // plain noise: every field fully random, reserved methods included
    if (chance(10)) begin
      r.mode           = 3'($urandom_range(7));
      r.own_segment    = 2'($urandom_range(3));
      r.target_segment = 2'($urandom_range(3));
      r.patch_offset   = $urandom;
      r.addend         = $urandom;
      r.shrink_delta   = $urandom;
      r.instr_word     = $urandom;
      return r;
    end
    r.mode = 3'($urandom_range(5));
    if (chance(90)) r.own_segment = chance(50) ? rrp_pkg::SEG_CODE : rrp_pkg::SEG_DATA;
    else            r.own_segment = chance(50) ? rrp_pkg::SEG_ABS : rrp_pkg::SEG_BSS;
    r.target_segment = 2'($urandom_range(3));
    r.patch_offset   = chance(50) ? ($urandom_range(1023) << 2) : $urandom;
    if (chance(50))      r.shrink_delta = 32'd0;
    else if (chance(50)) r.shrink_delta = $urandom_range(255) << 1;
    else                 r.shrink_delta = $urandom;

    // displacement near the compressed-form limits most of the time
    case (r.mode)
      rrp_pkg::MODE_BRANCH12: begin
        d = chance(60) ? $urandom_range(520) - 260 : $urandom_range(8191) - 4096;
        if (chance(85)) d[0] = 1'b0;
      end
      rrp_pkg::MODE_JAL20: begin
        d = chance(60) ? $urandom_range(4200) - 2100 : $urandom_range(2097151) - 1048576;
        if (chance(85)) d[0] = 1'b0;
      end
      rrp_pkg::MODE_LOAD12, rrp_pkg::MODE_STORE12: begin
        if (chance(55))      d = $urandom_range(33) << 2;
        else if (chance(55)) d = $urandom_range(4095);
        else                 d = $urandom;
      end
      default: d = $urandom;
    endcase
    r.addend = addend_for(r.mode, r.own_segment, r.target_segment, r.patch_offset,
                          r.shrink_delta, d);

    // well-formed instruction for the method, with random immediate bits
    rd = 5'($urandom);
    ra = pick_reg();
    rb = 5'($urandom);
    f3 = 3'($urandom);
    op = 7'($urandom);
    case (r.mode)
      rrp_pkg::MODE_BRANCH12: begin
        op   = rrp_pkg::OPC_BRANCH;
        if (chance(85)) f3 = {2'b00, 1'($urandom)};
        if (chance(85)) rb = rrp_pkg::REG_ZERO;
        mask = 32'hFE00_0F80;
      end
      rrp_pkg::MODE_LOAD12: begin
        op   = rrp_pkg::OPC_LOAD;
        if (chance(85)) f3 = rrp_pkg::F3_WORD;
        rd   = pick_reg();
        mask = 32'hFFF0_0000;
      end
      rrp_pkg::MODE_STORE12: begin
        op   = rrp_pkg::OPC_STORE;
        if (chance(85)) f3 = rrp_pkg::F3_WORD;
        rb   = pick_reg();
        mask = 32'hFE00_0F80;
      end
      rrp_pkg::MODE_JAL20: begin
        op   = rrp_pkg::OPC_JAL;
        if (chance(85)) rd = rrp_pkg::REG_RA;
        mask = 32'hFFFF_F000;
      end
      default: mask = 32'hFFFF_F000;
    endcase
    if (chance(10)) op = 7'($urandom);
    r.instr_word = rv_word(op, f3, rd, ra, rb);
    if (chance(50)) r.instr_word = r.instr_word | ($urandom & mask);
    return r;
  endfunction

  task automatic queue_reloc(rrp_pkg::reloc_t r);
    reloc_q.push_back(r);
    queued_total++;
  endtask

  task automatic queue_disp(logic [2:0] mode, logic [1:0] own, logic [1:0] tgt,
                            logic [31:0] pofs, logic [31:0] dlt, logic [31:0] disp,
                            logic [31:0] w);
    rrp_pkg::reloc_t r;
    r.mode           = mode;
    r.own_segment    = own;
    r.target_segment = tgt;
    r.patch_offset   = pofs;
    r.shrink_delta   = dlt;
    r.addend         = addend_for(mode, own, tgt, pofs, dlt, disp);
    r.instr_word     = w;
    queue_reloc(r);
  endtask

  task automatic set_reloc_reg(rrp_pkg::cfg_idx_e idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    case (idx)
      rrp_pkg::CFG_COMPRESS_EN: cfg_shadow.compress_en = val[0];
      rrp_pkg::CFG_CODE_BASE:   cfg_shadow.code_base   = val;
      rrp_pkg::CFG_DATA_BASE:   cfg_shadow.data_base   = val;
      rrp_pkg::CFG_BSS_BASE:    cfg_shadow.bss_base    = val;
      default: ;
    endcase
  endtask

  task automatic apply_layout(logic en, logic [31:0] code, logic [31:0] data,
                              logic [31:0] bss);
    set_reloc_reg(rrp_pkg::CFG_COMPRESS_EN, {31'd0, en});
    set_reloc_reg(rrp_pkg::CFG_CODE_BASE, code);
    set_reloc_reg(rrp_pkg::CFG_DATA_BASE, data);
    set_reloc_reg(rrp_pkg::CFG_BSS_BASE, bss);
  endtask

  // Sender stays quiet until every queued request has come back.
  task automatic wait_drained();
    while (results_seen < queued_total) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random(int unsigned n);
    repeat (n) queue_reloc(rand_reloc());
  endtask

  // --------------------------------------------------------------------------
  // Request driver: bursts of random length, random gaps in between.
  // The prediction is made when the request is taken.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready_o) begin
        patch_exp_q.push_back(patch_predict(cur_reloc));
      end
      if (!in_valid || in_ready_o) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (reloc_q.size() == 0) begin
          in_valid <= 1'b0;
        end else begin
          cur_reloc <= reloc_q.pop_front();
          in_valid  <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= chance(15) ? 80 : $urandom_range(1, 24);
            gap_left   <= chance(30) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor and checker. Ready follows a rotating pattern; once, after
  // HOLD_AT results, it drops for the LONG_HOLD stretch so both stages fill up.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_mon
    rrp_pkg::result_t exp_r;
    if (rst_n) begin
      if (out_valid_o && out_ready) begin
        results_seen <= results_seen + 1;
        if (patch_exp_q.size() == 0) begin
          $error("result with no request pending: patched_word %h", patched_word_o);
          mismatches++;
        end else begin
          exp_r = patch_exp_q.pop_front();
          if (patched_word_o !== exp_r.patched_word) begin
            $error("patched_word: expected %h, got %h", exp_r.patched_word, patched_word_o);
            mismatches++;
          end
          if (compressed_o !== exp_r.compressed) begin
            $error("compressed: expected %b, got %b", exp_r.compressed, compressed_o);
            mismatches++;
          end
          if (status_o !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_o);
            mismatches++;
          end
        end
      end

      tick <= tick + 1;
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (!long_hold_done && results_seen >= HOLD_AT) begin
        long_hold_done <= 1'b1;
        hold_left      <= LONG_HOLD - 1;
        out_ready      <= 1'b0;
      end else begin
        case ((tick / 128) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= chance(50);
          2: out_ready <= (tick % 3 == 0);
          default: out_ready <= chance(80);
        endcase
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
          (cfg_valid && cfg_ready_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // reset layout: all starts zero, compression off
    queue_random(30);
    wait_drained();

    apply_layout(1'b1, 32'h1000_0000, 32'h2000_0000, 32'h3000_0000);
    // segment check comes before the method check
    queue_disp(MODE_RSVD7, rrp_pkg::SEG_ABS, rrp_pkg::SEG_CODE, 32'd0, 32'd0, 32'd0,
               32'hFFFF_FFFF);
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_BSS, rrp_pkg::SEG_DATA, 32'd0, 32'd0,
               32'd8, rv_word(rrp_pkg::OPC_BRANCH, 3'b000, 5'd0, 5'd8, rrp_pkg::REG_ZERO));
    // reserved methods
    queue_disp(MODE_RSVD6, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h40, 32'd0, 32'd0,
               32'h1234_5678);
    queue_disp(MODE_RSVD7, rrp_pkg::SEG_DATA, rrp_pkg::SEG_BSS, 32'h40, 32'd0, 32'd0, 32'd0);
    // absolute word at the extremes
    queue_disp(rrp_pkg::MODE_WORD32, rrp_pkg::SEG_DATA, rrp_pkg::SEG_BSS, 32'hFFFF_FFFF,
               32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
    queue_disp(rrp_pkg::MODE_WORD32, rrp_pkg::SEG_CODE, rrp_pkg::SEG_ABS, 32'd0, 32'd0,
               32'd0, 32'd0);
    // branches: odd offset, both ends of the c.beqz/c.bnez range, just outside
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h100, 32'd0,
               32'd3, rv_word(rrp_pkg::OPC_BRANCH, 3'b000, 5'd0, 5'd8, rrp_pkg::REG_ZERO));
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h200, 32'd4,
               -256, rv_word(rrp_pkg::OPC_BRANCH, 3'b000, 5'd0, 5'd8, rrp_pkg::REG_ZERO));
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h200, 32'd0,
               32'd254, rv_word(rrp_pkg::OPC_BRANCH, 3'b001, 5'd0, 5'd15, rrp_pkg::REG_ZERO));
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h200, 32'd0,
               32'd256, rv_word(rrp_pkg::OPC_BRANCH, 3'b001, 5'd0, 5'd9, rrp_pkg::REG_ZERO));
    queue_disp(rrp_pkg::MODE_BRANCH12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h200, 32'd0,
               32'd8, rv_word(rrp_pkg::OPC_BRANCH, 3'b000, 5'd0, 5'd9, 5'd3));
    // loads: c.lw limits, beyond them, negative and unaligned
    queue_disp(rrp_pkg::MODE_LOAD12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h80, 32'd0,
               32'd124, rv_word(rrp_pkg::OPC_LOAD, rrp_pkg::F3_WORD, 5'd8, 5'd15, 5'd0));
    queue_disp(rrp_pkg::MODE_LOAD12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h80, 32'd0,
               32'd0, rv_word(rrp_pkg::OPC_LOAD, rrp_pkg::F3_WORD, 5'd12, 5'd9, 5'd0));
    queue_disp(rrp_pkg::MODE_LOAD12, rrp_pkg::SEG_DATA, rrp_pkg::SEG_DATA, 32'h80, 32'd0,
               32'd128, rv_word(rrp_pkg::OPC_LOAD, rrp_pkg::F3_WORD, 5'd12, 5'd9, 5'd0));
    queue_disp(rrp_pkg::MODE_LOAD12, rrp_pkg::SEG_DATA, rrp_pkg::SEG_CODE, 32'h80, 32'd0,
               -4, rv_word(rrp_pkg::OPC_LOAD, rrp_pkg::F3_WORD, 5'd12, 5'd9, 5'd0));
    queue_disp(rrp_pkg::MODE_LOAD12, rrp_pkg::SEG_DATA, rrp_pkg::SEG_BSS, 32'h80, 32'd0,
               32'd6, rv_word(rrp_pkg::OPC_LOAD, rrp_pkg::F3_WORD, 5'd12, 5'd9, 5'd0));
    // stores: compressible and with a full-width source register
    queue_disp(rrp_pkg::MODE_STORE12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h90, 32'd8,
               32'd64, rv_word(rrp_pkg::OPC_STORE, rrp_pkg::F3_WORD, 5'd0, 5'd11, 5'd10));
    queue_disp(rrp_pkg::MODE_STORE12, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h90, 32'd8,
               32'd8, rv_word(rrp_pkg::OPC_STORE, rrp_pkg::F3_WORD, 5'd0, 5'd11, 5'd5));
    // upper part with and without rounding
    queue_disp(rrp_pkg::MODE_HIGH20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_DATA, 32'h100, 32'd0,
               32'h0000_0800, 32'h0000_0537);
    queue_disp(rrp_pkg::MODE_HIGH20, rrp_pkg::SEG_DATA, rrp_pkg::SEG_CODE, 32'h100, 32'd0,
               32'hFFFF_F7FF, 32'h0000_0517);
    // jal: both ends of the c.jal range, just outside, odd, wrong link register
    queue_disp(rrp_pkg::MODE_JAL20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h400, 32'd0,
               -2048, rv_word(rrp_pkg::OPC_JAL, 3'b000, rrp_pkg::REG_RA, 5'd0, 5'd0));
    queue_disp(rrp_pkg::MODE_JAL20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h400, 32'd2,
               32'd2046, rv_word(rrp_pkg::OPC_JAL, 3'b000, rrp_pkg::REG_RA, 5'd0, 5'd0));
    queue_disp(rrp_pkg::MODE_JAL20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h400, 32'd0,
               32'd2048, rv_word(rrp_pkg::OPC_JAL, 3'b000, rrp_pkg::REG_RA, 5'd0, 5'd0));
    queue_disp(rrp_pkg::MODE_JAL20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h400, 32'd0,
               32'd1, rv_word(rrp_pkg::OPC_JAL, 3'b000, rrp_pkg::REG_RA, 5'd0, 5'd0));
    queue_disp(rrp_pkg::MODE_JAL20, rrp_pkg::SEG_CODE, rrp_pkg::SEG_CODE, 32'h400, 32'd0,
               32'd100, rv_word(rrp_pkg::OPC_JAL, 3'b000, 5'd5, 5'd0, 5'd0));
    queue_random(200);
    wait_drained();

    // extreme layout
    apply_layout(1'b1, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    queue_random(150);
    wait_drained();

    apply_layout(1'b0, $urandom, $urandom, $urandom);
    queue_random(150);
    wait_drained();

    apply_layout(1'b1, $urandom, $urandom, $urandom);
    queue_random(220);
    wait_drained();

    if (mismatches == 0 && patch_exp_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### files.f
rtl/rrp_pkg.sv
rtl/rrp_patch_core.sv
rtl/riscv_reloc_patch_rvc_unit.sv
rtl/rrp_checker.sv
test/riscv_reloc_patch_rvc_unit_tb.sv
